FILE: design/two_tier_lru_demotion_cache_top_macros.svh
// ----------------------------------------------------------------------------
// Two-tier LRU demotion cache: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef TWO_TIER_LRU_DEMOTION_CACHE_TOP_MACROS_SVH
`define TWO_TIER_LRU_DEMOTION_CACHE_TOP_MACROS_SVH

// Same-cycle implication
`define TTLRU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define TTLRU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/ttlru_pkg.sv
// ----------------------------------------------------------------------------
// Two-tier LRU demotion cache package
// Shared constants, outcome codes, FSM states and tier command type.
// ----------------------------------------------------------------------------
package ttlru_pkg;

  // Default geometry
  localparam int ENTRIES_DEF  = 64;
  localparam int TAG_BITS_DEF = 32;

  // Register and field widths
  localparam int CAP_W   = 7;
  localparam int ID_W    = 32;
  localparam int CNT_W   = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Result outcome codes
  typedef enum logic [1:0] {
    OUTCOME_MISS      = 2'd0,
    OUTCOME_FAST_HIT  = 2'd1,
    OUTCOME_SLOW_HIT  = 2'd2
  } ttlru_outcome_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_UPDATE = 2'd2
  } ttlru_state_e;

  // Per-tier update command
  typedef struct packed {
    logic touch;  // move the matching entry to the most-recent end
    logic push;   // insert the head tag at the most-recent end
    logic pop;    // remove the least-recent entry
  } ttlru_tier_cmd_t;

endpackage

FILE: design/ttlru_cell.sv
// ----------------------------------------------------------------------------
// Two-tier LRU cell
// One recency slot: holds a tag and its valid bit, compares the tag with
// the lookup key and loads from its more-recent neighbor when shifted.
// ----------------------------------------------------------------------------
module ttlru_cell #(
  parameter int TAG_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic                valid_we_i,
  input  logic [TAG_BITS-1:0] tag_i,
  input  logic                valid_i,
  input  logic [TAG_BITS-1:0] key_i,
  output logic [TAG_BITS-1:0] tag_o,
  output logic                valid_o,
  output logic                match_o
);

  logic [TAG_BITS-1:0] tag_q;
  logic                valid_q;

  // Load tag from neighbor
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      tag_q <= tag_i;
    end
  end

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_we_i) begin
      valid_q <= valid_i;
    end
  end

  assign tag_o   = tag_q;
  assign valid_o = valid_q;
  assign match_o = valid_q && (tag_q == key_i);

endmodule

FILE: design/ttlru_tier.sv
// ----------------------------------------------------------------------------
// Two-tier LRU tier
// A chain of cells kept in recency order, cell 0 the most recent. Lookup
// registers the hit and the set of cells at or above the hit; update
// shifts the chain for a touch or an insert.
// ----------------------------------------------------------------------------
module ttlru_tier #(
  parameter int ENTRIES  = ttlru_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = ttlru_pkg::TAG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          lookup_i,
  input  logic [TAG_BITS-1:0]           key_i,
  input  ttlru_pkg::ttlru_tier_cmd_t    cmd_i,
  input  logic [TAG_BITS-1:0]           head_tag_i,
  output logic                          hit_o,
  output logic [TAG_BITS-1:0]           lru_tag_o,
  output logic [$clog2(ENTRIES+1)-1:0]  fill_o
);
  import ttlru_pkg::*;

  localparam int FILL_W = $clog2(ENTRIES+1);
  localparam int STEPS  = $clog2(ENTRIES);

  logic [TAG_BITS-1:0] tags    [ENTRIES];
  logic [ENTRIES-1:0]  valids;
  logic [ENTRIES-1:0]  match_vec;
  logic [ENTRIES-1:0]  shift_en;
  logic [ENTRIES-1:0]  sel_d, sel_q;
  logic                hit_q;
  logic [FILL_W-1:0]   fill_q;
  logic                valid_we;
  logic [ENTRIES:0]    valids_ext;
  logic [TAG_BITS-1:0] lru_tag;

  // Occupancy changes only when an insert is not paired with a removal
  assign valid_we = cmd_i.push && !cmd_i.pop;

  always_comb begin
    shift_en = '0;
    if (cmd_i.push) begin
      shift_en = '1;
    end else if (cmd_i.touch) begin
      shift_en = sel_q;
    end
  end

  // Cell chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [TAG_BITS-1:0] tag_in;
    logic                valid_in;
    if (i == 0) begin : g_head
      assign tag_in   = head_tag_i;
      assign valid_in = 1'b1;
    end else begin : g_body
      assign tag_in   = tags[i-1];
      assign valid_in = valids[i-1];
    end
    ttlru_cell #(
      .TAG_BITS(TAG_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (shift_en[i]),
      .valid_we_i(valid_we),
      .tag_i     (tag_in),
      .valid_i   (valid_in),
      .key_i     (key_i),
      .tag_o     (tags[i]),
      .valid_o   (valids[i]),
      .match_o   (match_vec[i])
    );
  end

  // Mark every cell at or more recent than the hit (suffix OR, log steps)
  always_comb begin
    sel_d = match_vec;
    for (int k = 0; k < STEPS; k++) begin
      sel_d = sel_d | (sel_d >> (1 << k));
    end
  end

  // Register lookup result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= '0;
      hit_q <= 1'b0;
    end else if (lookup_i) begin
      sel_q <= sel_d;
      hit_q <= |match_vec;
    end
  end

  // Track fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (valid_we) begin
      fill_q <= fill_q + FILL_W'(1);
    end
  end

  // Select the least-recent valid cell
  assign valids_ext = {1'b0, valids};
  always_comb begin
    lru_tag = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valids_ext[i] && !valids_ext[i+1]) begin
        lru_tag = lru_tag | tags[i];
      end
    end
  end

  assign hit_o     = hit_q;
  assign lru_tag_o = lru_tag;
  assign fill_o    = fill_q;

endmodule

FILE: design/two_tier_lru_demotion_cache_top.sv
// ----------------------------------------------------------------------------
// Two-tier LRU demotion cache top level
// Looks up each block access in a fast and a slow LRU tier, inserts misses
// into the fast tier and, when it is full, demotes its least-recent block to the slow tier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries block_id_i and is_read_i.
//   Output channel (out_valid_o / out_ready_i) carries the outcome, any
//   demoted and dropped block, the slow write-hit flag and the running
//   saturating counters. One result transaction per input transaction.
//   cfg_we_i writes tier_capacity from cfg_wdata_i; write it only while idle.
//   An accepted transaction passes the lookup state (tag compare in
//   every cell, hit registered) and then the update state (chain shift
//   and result capture); a new transaction is taken in the update cycle
//   of the previous one.
//   The output register holds a result while the receiver stalls; lookup
//   of the next transaction still proceeds, and its update waits until
//   the output register is free.
//   Reset clears all valid bits, fill counts and counters at once and sets
//   the capacity to 64; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "two_tier_lru_demotion_cache_top_macros.svh"

module two_tier_lru_demotion_cache_top #(
  parameter int ENTRIES  = ttlru_pkg::ENTRIES_DEF,
  parameter int TAG_BITS = ttlru_pkg::TAG_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ttlru_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ttlru_pkg::ID_W-1:0] block_id_i,
  input  logic                       is_read_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 outcome_o,
  output logic                       demoted_valid_o,
  output logic [ttlru_pkg::ID_W-1:0] demoted_block_o,
  output logic                       dropped_valid_o,
  output logic [ttlru_pkg::ID_W-1:0] dropped_block_o,
  output logic                       slow_write_hit_o,
  output logic [ttlru_pkg::CNT_W-1:0] access_count_o,
  output logic [ttlru_pkg::CNT_W-1:0] hit_count_o,
  output logic [ttlru_pkg::CNT_W-1:0] slow_write_count_o
);
  import ttlru_pkg::*;

  localparam int FILL_W = $clog2(ENTRIES+1);
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  ttlru_state_e        state_q, state_d;
  logic [CAP_W-1:0]    cap_q;
  logic [TAG_BITS-1:0] key_q;
  logic                is_read_q;

  logic                accept;
  logic                upd_go;
  logic                lookup;

  ttlru_tier_cmd_t     fast_cmd, slow_cmd;
  logic                fast_hit, slow_hit;
  logic [TAG_BITS-1:0] fast_lru, slow_lru, slow_head;
  logic [FILL_W-1:0]   fast_fill, slow_fill;

  logic [CMP_W-1:0]    cap_ext, cap_eff;
  logic                fast_full, slow_full, miss;

  logic [ID_W+TAG_BITS-1:0] id_ext;
  logic [TAG_BITS+ID_W-1:0] dem_ext, drp_ext;

  ttlru_outcome_e      outcome_d, outcome_q;
  logic                out_valid_q;
  logic                dem_v_q, drp_v_q, sw_q, sw_d;
  logic [ID_W-1:0]     dem_b_q, drp_b_q;
  logic [CNT_W-1:0]    acc_cnt_q, hit_cnt_q, sw_cnt_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // Clamp capacity to 1..ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  // Handshake and controller
  assign upd_go     = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_UPDATE) && upd_go);
  assign accept     = in_valid_i && in_ready_o;
  assign lookup     = (state_q == ST_LOOKUP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (upd_go) state_d = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Capture the accepted transaction
  assign id_ext = {{TAG_BITS{1'b0}}, block_id_i};
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q     <= id_ext[TAG_BITS-1:0];
      is_read_q <= is_read_i;
    end
  end

  // Decide tier commands
  assign fast_full = CMP_W'(fast_fill) >= cap_eff;
  assign slow_full = CMP_W'(slow_fill) >= cap_eff;
  assign miss      = !fast_hit && !slow_hit;

  always_comb begin
    fast_cmd = '0;
    slow_cmd = '0;
    if ((state_q == ST_UPDATE) && upd_go) begin
      fast_cmd.touch = fast_hit;
      fast_cmd.push  = miss;
      fast_cmd.pop   = miss && fast_full;
      slow_cmd.touch = !fast_hit && slow_hit;
      slow_cmd.push  = miss && fast_full;
      slow_cmd.pop   = miss && fast_full && slow_full;
    end
  end

  assign slow_head = slow_cmd.push ? fast_lru : key_q;

  ttlru_tier #(
    .ENTRIES (ENTRIES),
    .TAG_BITS(TAG_BITS)
  ) u_fast (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lookup_i  (lookup),
    .key_i     (key_q),
    .cmd_i     (fast_cmd),
    .head_tag_i(key_q),
    .hit_o     (fast_hit),
    .lru_tag_o (fast_lru),
    .fill_o    (fast_fill)
  );

  ttlru_tier #(
    .ENTRIES (ENTRIES),
    .TAG_BITS(TAG_BITS)
  ) u_slow (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lookup_i  (lookup),
    .key_i     (key_q),
    .cmd_i     (slow_cmd),
    .head_tag_i(slow_head),
    .hit_o     (slow_hit),
    .lru_tag_o (slow_lru),
    .fill_o    (slow_fill)
  );

  // Build result fields
  always_comb begin
    if (fast_hit) begin
      outcome_d = OUTCOME_FAST_HIT;
    end else if (slow_hit) begin
      outcome_d = OUTCOME_SLOW_HIT;
    end else begin
      outcome_d = OUTCOME_MISS;
    end
  end
  assign sw_d    = !fast_hit && slow_hit && !is_read_q;
  assign dem_ext = {{ID_W{1'b0}}, fast_lru};
  assign drp_ext = {{ID_W{1'b0}}, slow_lru};

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_UPDATE) && upd_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_UPDATE) && upd_go) begin
      outcome_q <= outcome_d;
      dem_v_q   <= slow_cmd.push;
      dem_b_q   <= slow_cmd.push ? dem_ext[ID_W-1:0] : '0;
      drp_v_q   <= slow_cmd.pop;
      drp_b_q   <= slow_cmd.pop ? drp_ext[ID_W-1:0] : '0;
      sw_q      <= sw_d;
    end
  end

  // Saturating counters; they change only when the output register loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_cnt_q <= '0;
      hit_cnt_q <= '0;
      sw_cnt_q  <= '0;
    end else if ((state_q == ST_UPDATE) && upd_go) begin
      if (acc_cnt_q != '1) acc_cnt_q <= acc_cnt_q + CNT_W'(1);
      if (!miss && (hit_cnt_q != '1)) hit_cnt_q <= hit_cnt_q + CNT_W'(1);
      if (sw_d && (sw_cnt_q != '1)) sw_cnt_q <= sw_cnt_q + CNT_W'(1);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign outcome_o          = outcome_q;
  assign demoted_valid_o    = dem_v_q;
  assign demoted_block_o    = dem_b_q;
  assign dropped_valid_o    = drp_v_q;
  assign dropped_block_o    = drp_b_q;
  assign slow_write_hit_o   = sw_q;
  assign access_count_o     = acc_cnt_q;
  assign hit_count_o        = hit_cnt_q;
  assign slow_write_count_o = sw_cnt_q;

  // Assertions
  `TTLRU_ASSERT_NOW(a_tiers_exclusive, clk_i, rst_ni, state_q == ST_UPDATE,
    !(fast_hit && slow_hit), "block found in both tiers")
  `TTLRU_ASSERT_NOW(a_demote_on_miss, clk_i, rst_ni, out_valid_q && dem_v_q,
    outcome_q == OUTCOME_MISS, "demotion reported on a hit")
  `TTLRU_ASSERT_NOW(a_drop_needs_demote, clk_i, rst_ni, out_valid_q && drp_v_q,
    dem_v_q, "slow-tier drop without a demotion")
  `TTLRU_ASSERT_NEXT(a_fill_bounded, clk_i, rst_ni, 1'b1,
    (CMP_W'(fast_fill) <= CMP_W'(ENTRIES)) && (CMP_W'(slow_fill) <= CMP_W'(ENTRIES)),
    "tier fill count exceeds entries")

endmodule
